>>> rtl/imd_pkg.sv
// Shared types and constants of the IMU motion detector core.
// Holds register indexes, reset values, window class codes and the abs helpers.
// No dependencies.
package imd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 22;
    localparam int QUICK_W    = 17;
    localparam int WIN_W      = 4;
    localparam int HOLD_W     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;
    localparam int CHANGE_W   = 18;   // three abs deltas of up to 65535
    localparam int MAG_W      = 17;   // three abs values of up to 32768

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [SUM_W-1:0]   RST_ACCEL_LOW  = 22'd5250;
    localparam logic [SUM_W-1:0]   RST_ACCEL_HIGH = 22'd75000;
    localparam logic [SUM_W-1:0]   RST_GYRO_LOW   = 22'd4500;
    localparam logic [SUM_W-1:0]   RST_GYRO_HIGH  = 22'd82500;
    localparam logic [QUICK_W-1:0] RST_QUICK      = 17'd40960;
    localparam logic [WIN_W-1:0]   RST_WINDOW     = 4'd10;
    localparam logic [HOLD_W-1:0]  RST_HOLD       = 5'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACCEL_LOW  = 3'd0,
        REG_ACCEL_HIGH = 3'd1,
        REG_GYRO_LOW   = 3'd2,
        REG_GYRO_HIGH  = 3'd3,
        REG_QUICK      = 3'd4,
        REG_WINDOW     = 3'd5,
        REG_HOLD       = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        CLASS_NONE        = 3'd0,
        CLASS_GYRO_LARGE  = 3'd1,
        CLASS_ACCEL_LARGE = 3'd2,
        CLASS_BOTH_LARGE  = 3'd3,
        CLASS_ACCEL_SMALL = 3'd4
    } window_class_t;

    // Magnitude of a 16-bit two's complement value; -32768 maps to 32768.
    function automatic logic [SAMPLE_W-1:0] abs16(input logic signed [SAMPLE_W-1:0] v);
        logic [SAMPLE_W-1:0] neg;
        neg = ~v + 1'b1;
        return v[SAMPLE_W-1] ? neg : v;
    endfunction

    // Magnitude of the difference of two 16-bit samples, always below 65536.
    function automatic logic [SAMPLE_W-1:0] abs_diff16(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b
    );
        logic [SAMPLE_W:0] d;
        logic [SAMPLE_W:0] neg;
        d   = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
        neg = ~d + 1'b1;
        return d[SAMPLE_W] ? neg[SAMPLE_W-1:0] : d[SAMPLE_W-1:0];
    endfunction

endpackage

>>> rtl/imu_motion_detector_core.sv
// IMU motion detector core: windowed accel-change and gyro-magnitude sums,
// threshold flags, motion hold timer and sticky quick-motion flag.
// Depends on imd_pkg.
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+--------------------------------------
//  in      | input     | in_valid / in_ready     | accel_x/y/z, gyro_x/y/z (16b signed)
//  out     | output    | out_valid / out_ready   | motion_active .. window_class
//  cfg     | input     | cfg_wr_en (no stall)    | cfg_index, cfg_data
//
// Each transaction passes two register stages: the sample register, then the
// result register, which holds its result valid until it is taken.
// One transaction is taken every cycle while the output side keeps up; the
// whole evaluation of a sample fits between the sample and result registers.
// When the result register is full and not taken, both stages hold and in_ready
// drops only if the sample register is also full.
// Reset clears all thresholds to their defaults and all window and hold state.
module imu_motion_detector_core
    import imd_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [SAMPLE_W-1:0]   accel_x,
    input  logic signed [SAMPLE_W-1:0]   accel_y,
    input  logic signed [SAMPLE_W-1:0]   accel_z,
    input  logic signed [SAMPLE_W-1:0]   gyro_x,
    input  logic signed [SAMPLE_W-1:0]   gyro_y,
    input  logic signed [SAMPLE_W-1:0]   gyro_z,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         motion_active,
    output logic                         quick_motion,
    output logic                         accel_large,
    output logic                         accel_small,
    output logic                         gyro_large,
    output logic                         gyro_small,
    output logic                         window_done,
    output logic [2:0]                   window_class
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]   accel_low_reg;
    logic [SUM_W-1:0]   accel_high_reg;
    logic [SUM_W-1:0]   gyro_low_reg;
    logic [SUM_W-1:0]   gyro_high_reg;
    logic [QUICK_W-1:0] quick_thr_reg;
    logic [WIN_W-1:0]   window_len_reg;
    logic [HOLD_W-1:0]  hold_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_low_reg  <= RST_ACCEL_LOW;
            accel_high_reg <= RST_ACCEL_HIGH;
            gyro_low_reg   <= RST_GYRO_LOW;
            gyro_high_reg  <= RST_GYRO_HIGH;
            quick_thr_reg  <= RST_QUICK;
            window_len_reg <= RST_WINDOW;
            hold_len_reg   <= RST_HOLD;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ACCEL_LOW:  accel_low_reg  <= cfg_data;
                REG_ACCEL_HIGH: accel_high_reg <= cfg_data;
                REG_GYRO_LOW:   gyro_low_reg   <= cfg_data;
                REG_GYRO_HIGH:  gyro_high_reg  <= cfg_data;
                REG_QUICK:      quick_thr_reg  <= cfg_data[QUICK_W-1:0];
                REG_WINDOW:     window_len_reg <= cfg_data[WIN_W-1:0];
                REG_HOLD:       hold_len_reg   <= cfg_data[HOLD_W-1:0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. The sample stage advances into the result stage
    // whenever the result register is empty or being drained.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic s1_fire;
    logic in_fire;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign in_fire  = in_valid && in_ready;

    // Sample register (payload, no reset).
    logic signed [SAMPLE_W-1:0] ax_reg, ay_reg, az_reg;
    logic signed [SAMPLE_W-1:0] gx_reg, gy_reg, gz_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ax_reg <= accel_x;
            ay_reg <= accel_y;
            az_reg <= accel_z;
            gx_reg <= gyro_x;
            gy_reg <= gyro_y;
            gz_reg <= gyro_z;
        end
    end

    // ------------------------------------------------------------------
    // Detector state.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] prev_ax_reg, prev_ay_reg, prev_az_reg;
    logic [SUM_W-1:0]  accel_sum_reg, accel_sum_next;
    logic [SUM_W-1:0]  gyro_sum_reg, gyro_sum_next;
    logic [WIN_W-1:0]  win_cnt_reg, win_cnt_next;
    logic              accel_large_reg, accel_large_next;
    logic              accel_small_reg, accel_small_next;
    logic              gyro_large_reg, gyro_large_next;
    logic              gyro_small_reg, gyro_small_next;
    logic              win_motion_reg, win_motion_next;
    logic [HOLD_W-1:0] hold_cnt_reg, hold_cnt_next;
    logic              hold_active_reg, hold_active_next;
    logic              quick_reg, quick_next;

    // Output register fields that are not copies of state.
    logic              done_reg;
    logic [2:0]        class_reg;

    // ------------------------------------------------------------------
    // Per-sample evaluation.
    // ------------------------------------------------------------------
    logic [CHANGE_W-1:0] change;
    logic [MAG_W-1:0]    gyro_mag;
    logic [MAG_W-1:0]    inst_mag;
    logic [SUM_W:0]      accel_add;
    logic [SUM_W:0]      gyro_add;
    logic [SUM_W-1:0]    accel_sum_sat;
    logic [SUM_W-1:0]    gyro_sum_sat;
    logic [WIN_W-1:0]    win_cnt_inc;
    logic                done_next;
    window_class_t       class_next;

    always_comb
    begin
        change = CHANGE_W'(abs_diff16(prev_ax_reg, ax_reg))
               + CHANGE_W'(abs_diff16(prev_ay_reg, ay_reg))
               + CHANGE_W'(abs_diff16(prev_az_reg, az_reg));
        inst_mag = MAG_W'(abs16(ax_reg)) + MAG_W'(abs16(ay_reg)) + MAG_W'(abs16(az_reg));
        gyro_mag = MAG_W'(abs16(gx_reg)) + MAG_W'(abs16(gy_reg)) + MAG_W'(abs16(gz_reg));

        // Both window sums clip at full scale instead of wrapping.
        accel_add     = {1'b0, accel_sum_reg} + (SUM_W+1)'(change);
        gyro_add      = {1'b0, gyro_sum_reg} + (SUM_W+1)'(gyro_mag);
        accel_sum_sat = accel_add[SUM_W] ? SUM_MAX : accel_add[SUM_W-1:0];
        gyro_sum_sat  = gyro_add[SUM_W] ? SUM_MAX : gyro_add[SUM_W-1:0];

        quick_next = quick_reg || (inst_mag > quick_thr_reg);

        // A window length of zero behaves as one: every sample closes.
        win_cnt_inc = win_cnt_reg + 1'b1;
        done_next   = (win_cnt_inc >= window_len_reg);

        accel_sum_next   = accel_sum_sat;
        gyro_sum_next    = gyro_sum_sat;
        win_cnt_next     = win_cnt_inc;
        accel_large_next = accel_large_reg;
        accel_small_next = accel_small_reg;
        gyro_large_next  = gyro_large_reg;
        gyro_small_next  = gyro_small_reg;
        win_motion_next  = win_motion_reg;
        class_next       = CLASS_NONE;

        if (done_next)
        begin
            win_cnt_next   = '0;
            accel_sum_next = '0;
            gyro_sum_next  = '0;

            // Above both accel thresholds the small flag keeps its old value.
            if (accel_sum_sat > accel_low_reg)
            begin
                if (accel_sum_sat > accel_high_reg)
                begin
                    accel_large_next = 1'b1;
                end
                else
                begin
                    accel_large_next = 1'b0;
                    accel_small_next = 1'b1;
                end
            end
            else
            begin
                accel_large_next = 1'b0;
                accel_small_next = 1'b0;
            end

            gyro_small_next = (gyro_sum_sat > gyro_low_reg);
            gyro_large_next = gyro_small_next && (gyro_sum_sat > gyro_high_reg);

            if (gyro_large_next && !accel_large_next)
                class_next = CLASS_GYRO_LARGE;
            else if (accel_large_next && !gyro_large_next)
                class_next = CLASS_ACCEL_LARGE;
            else if (accel_large_next && gyro_large_next)
                class_next = CLASS_BOTH_LARGE;
            else if (accel_small_next)
                class_next = CLASS_ACCEL_SMALL;
            else
                class_next = CLASS_NONE;

            win_motion_next = accel_large_next || gyro_large_next;
        end

        // Motion reloads the hold timer; afterwards it counts down, and the
        // output drops one sample after the counter has reached zero.
        hold_cnt_next    = hold_cnt_reg;
        hold_active_next = hold_active_reg;
        if (win_motion_next)
        begin
            hold_active_next = 1'b1;
            hold_cnt_next    = hold_len_reg;
        end
        else if (hold_active_reg)
        begin
            if (hold_cnt_reg != '0)
                hold_cnt_next = hold_cnt_reg - 1'b1;
            else
                hold_active_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Control state, detector state and result register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            prev_ax_reg     <= '0;
            prev_ay_reg     <= '0;
            prev_az_reg     <= '0;
            accel_sum_reg   <= '0;
            gyro_sum_reg    <= '0;
            win_cnt_reg     <= '0;
            accel_large_reg <= 1'b0;
            accel_small_reg <= 1'b0;
            gyro_large_reg  <= 1'b0;
            gyro_small_reg  <= 1'b0;
            win_motion_reg  <= 1'b0;
            hold_cnt_reg    <= '0;
            hold_active_reg <= 1'b0;
            quick_reg       <= 1'b0;
            done_reg        <= 1'b0;
            class_reg       <= CLASS_NONE;
        end
        else
        begin
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            if (s1_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (s1_fire)
            begin
                prev_ax_reg     <= ax_reg;
                prev_ay_reg     <= ay_reg;
                prev_az_reg     <= az_reg;
                accel_sum_reg   <= accel_sum_next;
                gyro_sum_reg    <= gyro_sum_next;
                win_cnt_reg     <= win_cnt_next;
                accel_large_reg <= accel_large_next;
                accel_small_reg <= accel_small_next;
                gyro_large_reg  <= gyro_large_next;
                gyro_small_reg  <= gyro_small_next;
                win_motion_reg  <= win_motion_next;
                hold_cnt_reg    <= hold_cnt_next;
                hold_active_reg <= hold_active_next;
                quick_reg       <= quick_next;
                done_reg        <= done_next;
                class_reg       <= class_next;
            end
        end
    end

    // The state registers change only when a result is loaded, so they
    // double as the stable payload of the result register.
    assign out_valid     = out_valid_reg;
    assign motion_active = hold_active_reg;
    assign quick_motion  = quick_reg;
    assign accel_large   = accel_large_reg;
    assign accel_small   = accel_small_reg;
    assign gyro_large    = gyro_large_reg;
    assign gyro_small    = gyro_small_reg;
    assign window_done   = done_reg;
    assign window_class  = class_reg;

`ifndef SYNTHESIS
    a_class_only_at_close: assert property (@(posedge clk) disable iff (!rst_n)
        !done_reg |-> (class_reg == CLASS_NONE))
        else $error("window class set on a sample that did not close a window");

    a_large_means_motion: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (accel_large_reg || gyro_large_reg) |-> hold_active_reg)
        else $error("large motion at window close without motion output");

    a_quick_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(quick_reg))
        else $error("quick-motion flag cleared outside reset");

    a_close_resets_window: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && done_next |=> (win_cnt_reg == '0) && (accel_sum_reg == '0)
                                  && (gyro_sum_reg == '0))
        else $error("window state not cleared after window close");

    a_result_slot_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(hold_cnt_reg)
                                         && $stable(win_cnt_reg))
        else $error("detector state advanced while result was stalled");
`endif

endmodule
